[hw/rtl/bitmap_slot_allocator_macros.svh]
// Assertion macros shared by the bitmap slot allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define BSA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bitmap_slot_allocator: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define BSA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_slot_allocator: implication violated");

// The consequent holds in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_slot_allocator: next-cycle implication violated");

`endif

[hw/rtl/bsa_pkg.sv]
// Shared types, constants and bit functions of the bitmap slot allocator.
`default_nettype none

package bsa_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BIT_IDX_W  = 6;
    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 10;
    localparam int OFFSET_W   = 26;
    localparam int COUNT_W    = 11;
    localparam int HEADROOM_W = 6;
    localparam int SIZE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM_SLOTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE    = 2'd2;

    localparam logic [COUNT_W-1:0]    OBJECT_COUNT_RST   = 11'd1024;
    localparam logic [HEADROOM_W-1:0] HEADROOM_SLOTS_RST = 6'd1;
    localparam logic [SIZE_W-1:0]     OBJECT_SIZE_RST    = 16'd64;

    typedef struct packed {
        logic start;
        logic start_init;
        logic start_alloc;
        logic rd_en;
        logic rd_free;
        logic step;
        logic rewind;
        logic wr_init;
        logic wr_free;
        logic wr_alloc;
        logic wr_retire;
        logic mul;
        logic set_ok;
        logic load_out;
    } bsa_cmd_t;

    typedef struct packed {
        logic free_in_span;
        logic full;
        logic match;
        logic last;
        logic out_free;
    } bsa_sts_t;

    function automatic logic [WORD_BITS-1:0] headroom_mask(input logic [HEADROOM_W-1:0] h);
        return (WORD_BITS'(1) << h) - WORD_BITS'(1);
    endfunction

    function automatic logic [WORD_BITS-1:0] padding_mask(input logic [BIT_IDX_W-1:0] pad);
        return ~({WORD_BITS{1'b1}} >> pad);
    endfunction

    function automatic logic [BIT_IDX_W-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (oh[i])
            begin
                idx = idx | BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bitmap_slot_allocator.sv]
// Top level of the bitmap slot allocator: controller, datapath and checks.
//
//  Channel  Direction  Handshake                 Word
//  in       input      in_valid / in_stall       func, slot_index
//  out      output     out_valid / out_stall     ok, slot, byte_offset
//  cfg      input      cfg_wr_en                 cfg_index, cfg_wdata
//
// Init writes every bitmap word of the span, alloc scans from the hint for a word that is
// not full, and free clears the slot's bit and then checks whether the span is empty.
// The bitmap memory has one write port and one registered read port, one word per cycle.
// Reset clears the bitmap through per-word valid bits, so no clearing pass is needed.
// A new word is accepted while the previous result waits in the output register.
`default_nettype none

`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator
#(
    parameter int MAX_WORDS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bsa_pkg::FUNC_W-1:0]         func,
    input  logic [bsa_pkg::SLOT_W-1:0]         slot_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic [bsa_pkg::SLOT_W-1:0]         slot,
    output logic [bsa_pkg::OFFSET_W-1:0]       byte_offset
);

    import bsa_pkg::*;

    bsa_cmd_t cmd;
    bsa_sts_t sts;

    bsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsa_dp
    #(
        .MAX_WORDS (MAX_WORDS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .slot_index  (slot_index),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .slot        (slot),
        .byte_offset (byte_offset)
    );

    `BSA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `BSA_ASSERT_IMPLY(a_fail_is_zero, out_valid && !ok, slot == '0 && byte_offset == '0)
    `BSA_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.wr_init, cmd.wr_free, cmd.wr_alloc, cmd.wr_retire}))
    `BSA_ASSERT_IMPLY(a_load_has_room, cmd.load_out, sts.out_free)

endmodule

`default_nettype wire

[hw/rtl/bsa_ctrl.sv]
// Controller state machine that sequences init, alloc and free over the bitmap words.
`default_nettype none

module bsa_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bsa_pkg::FUNC_W-1:0]   func,
    input  bsa_pkg::bsa_sts_t            sts,
    output bsa_pkg::bsa_cmd_t            cmd
);

    import bsa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_INIT_WR   = 11'b000_0000_0010,
        S_ALLOC_RD  = 11'b000_0000_0100,
        S_ALLOC_CHK = 11'b000_0000_1000,
        S_MUL       = 11'b000_0001_0000,
        S_FREE_RD   = 11'b000_0010_0000,
        S_FREE_WR   = 11'b000_0100_0000,
        S_EMPTY_RD  = 11'b000_1000_0000,
        S_EMPTY_CHK = 11'b001_0000_0000,
        S_RETIRE    = 11'b010_0000_0000,
        S_FINISH    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start       = 1'b1;
                    cmd.start_init  = (func == FUNC_INIT);
                    cmd.start_alloc = (func == FUNC_ALLOC);
                    case (func)
                        FUNC_INIT:  state_next = S_INIT_WR;
                        FUNC_ALLOC: state_next = S_ALLOC_RD;
                        FUNC_FREE:  state_next = S_FREE_RD;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_INIT_WR:
            begin
                cmd.wr_init = 1'b1;
                cmd.step    = 1'b1;
                if (sts.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_ALLOC_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                if (!sts.full)
                begin
                    cmd.wr_alloc = 1'b1;
                    state_next   = S_MUL;
                end
                else if (sts.last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step  = 1'b1;
                    cmd.rd_en = 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cmd.set_ok = 1'b1;
                state_next = S_FINISH;
            end
            S_FREE_RD:
            begin
                if (sts.free_in_span)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_free = 1'b1;
                    state_next  = S_FREE_WR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FREE_WR:
            begin
                cmd.wr_free = 1'b1;
                state_next  = S_EMPTY_RD;
            end
            S_EMPTY_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMPTY_CHK;
            end
            S_EMPTY_CHK:
            begin
                if (!sts.match)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.last)
                begin
                    cmd.rewind = 1'b1;
                    state_next = S_RETIRE;
                end
                else
                begin
                    cmd.step  = 1'b1;
                    cmd.rd_en = 1'b1;
                end
            end
            S_RETIRE:
            begin
                cmd.wr_retire = 1'b1;
                cmd.step      = 1'b1;
                if (sts.last)
                begin
                    cmd.set_ok = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bsa_dp.sv]
// Datapath: configuration registers, bitmap memory, scan pointer, multiplier and output word.
`default_nettype none

module bsa_dp
#(
    parameter int MAX_WORDS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [bsa_pkg::SLOT_W-1:0]         slot_index,
    input  bsa_pkg::bsa_cmd_t                  cmd,
    output bsa_pkg::bsa_sts_t                  sts,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic [bsa_pkg::SLOT_W-1:0]         slot,
    output logic [bsa_pkg::OFFSET_W-1:0]       byte_offset
);

    import bsa_pkg::*;

    localparam int WIW         = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCW         = $clog2(MAX_WORDS + 1);
    localparam int SLOT_FULL_W = WIW + BIT_IDX_W;
    localparam int PROD_W      = SLOT_FULL_W + SIZE_W;
    localparam int SPAN_W      = 16;
    localparam int CAP         = MAX_WORDS * WORD_BITS;

    logic [COUNT_W-1:0]     object_count_reg;
    logic [HEADROOM_W-1:0]  headroom_slots_reg;
    logic [SIZE_W-1:0]      object_size_reg;

    logic [WORD_BITS-1:0]   mem [MAX_WORDS];
    logic [MAX_WORDS-1:0]   valid_reg;
    logic [WORD_BITS-1:0]   rd_data_reg;
    logic                   rd_vld_reg;

    logic [WIW-1:0]         ptr_reg;
    logic [WCW-1:0]         cnt_reg;
    logic [WIW-1:0]         hint_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [SLOT_FULL_W-1:0] slot_reg;
    logic [OFFSET_W-1:0]    off_reg;
    logic                   res_ok_reg;

    logic                   out_vld_reg;
    logic                   out_ok_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [OFFSET_W-1:0]    out_off_reg;

    logic [SPAN_W-1:0]      ocount_ext;
    logic [SPAN_W-1:0]      span_count;
    logic [SPAN_W-1:0]      words_full;
    logic [WCW-1:0]         words;
    logic [WCW-1:0]         last_idx;
    logic [BIT_IDX_W-1:0]   pad;
    logic [WORD_BITS-1:0]   ptr_pat;
    logic                   ptr_is_last;
    logic [WIW-1:0]         ptr_nx;
    logic [WIW-1:0]         hint_adj;
    logic [WIW-1:0]         free_word;
    logic [WIW-1:0]         rd_addr;
    logic [WORD_BITS-1:0]   data;
    logic [WORD_BITS-1:0]   clear_oh;
    logic [BIT_IDX_W-1:0]   clear_bit;
    logic                   wr_en;
    logic [WIW-1:0]         wr_addr;
    logic [WORD_BITS-1:0]   wr_data;
    logic [PROD_W-1:0]      prod;

    // Span geometry from the live configuration.
    assign ocount_ext = SPAN_W'(object_count_reg);

    always_comb
    begin
        if (ocount_ext == '0)
        begin
            span_count = SPAN_W'(1);
        end
        else if (ocount_ext > SPAN_W'(CAP))
        begin
            span_count = SPAN_W'(CAP);
        end
        else
        begin
            span_count = ocount_ext;
        end
    end

    assign words_full = (span_count + SPAN_W'(WORD_BITS - 1)) >> BIT_IDX_W;
    assign words      = WCW'(words_full);
    assign last_idx   = words - WCW'(1);
    assign pad        = BIT_IDX_W'(0) - span_count[BIT_IDX_W-1:0];

    assign ptr_is_last = (WCW'(ptr_reg) == last_idx);
    assign ptr_nx      = ptr_is_last ? '0 : ptr_reg + WIW'(1);
    assign hint_adj    = (WCW'(hint_reg) >= words) ? '0 : hint_reg;
    assign free_word   = WIW'(idx_reg[SLOT_W-1:BIT_IDX_W]);

    assign ptr_pat = ((ptr_reg == '0) ? headroom_mask(headroom_slots_reg) : '0)
                   | (ptr_is_last ? padding_mask(pad) : '0);

    assign data      = rd_vld_reg ? rd_data_reg : '0;
    assign clear_oh  = ~data & (data + WORD_BITS'(1));
    assign clear_bit = onehot_index(clear_oh);

    assign rd_addr = cmd.rd_free ? free_word : (cmd.step ? ptr_nx : ptr_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = ptr_pat;
        if (cmd.wr_init)
        begin
            wr_en = 1'b1;
        end
        if (cmd.wr_free)
        begin
            wr_en   = 1'b1;
            wr_addr = free_word;
            wr_data = data & ~(WORD_BITS'(1) << idx_reg[BIT_IDX_W-1:0]);
        end
        if (cmd.wr_alloc)
        begin
            wr_en   = 1'b1;
            wr_data = data | clear_oh;
        end
        if (cmd.wr_retire)
        begin
            wr_en   = 1'b1;
            wr_data = '1;
        end
    end

    assign prod = PROD_W'(slot_reg) * PROD_W'(object_size_reg);

    assign sts.free_in_span = (32'(idx_reg[SLOT_W-1:BIT_IDX_W]) < 32'(words));
    assign sts.full         = &data;
    assign sts.match        = (data == ptr_pat);
    assign sts.last         = (cnt_reg == last_idx);
    assign sts.out_free     = !out_vld_reg || !out_stall;

    // Bitmap memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_count_reg   <= OBJECT_COUNT_RST;
            headroom_slots_reg <= HEADROOM_SLOTS_RST;
            object_size_reg    <= OBJECT_SIZE_RST;
            valid_reg          <= '0;
            rd_vld_reg         <= 1'b0;
            ptr_reg            <= '0;
            cnt_reg            <= '0;
            hint_reg           <= '0;
            out_vld_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_OBJECT_COUNT:   object_count_reg   <= cfg_wdata[COUNT_W-1:0];
                    CFG_HEADROOM_SLOTS: headroom_slots_reg <= cfg_wdata[HEADROOM_W-1:0];
                    CFG_OBJECT_SIZE:    object_size_reg    <= cfg_wdata[SIZE_W-1:0];
                    default:            object_size_reg    <= object_size_reg;
                endcase
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
            if (cmd.start)
            begin
                ptr_reg  <= cmd.start_alloc ? hint_adj : '0;
                cnt_reg  <= '0;
                hint_reg <= cmd.start_init ? '0 : hint_adj;
            end
            else if (cmd.rewind)
            begin
                ptr_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                ptr_reg <= ptr_nx;
                cnt_reg <= cnt_reg + WCW'(1);
            end
            if (cmd.wr_alloc)
            begin
                hint_reg <= ptr_reg;
            end
            if (cmd.load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx_reg    <= slot_index;
            slot_reg   <= '0;
            off_reg    <= '0;
            res_ok_reg <= 1'b0;
        end
        if (cmd.wr_alloc)
        begin
            slot_reg <= {ptr_reg, clear_bit};
        end
        if (cmd.mul)
        begin
            off_reg <= OFFSET_W'(prod);
        end
        if (cmd.set_ok)
        begin
            res_ok_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_ok_reg   <= res_ok_reg;
            out_slot_reg <= SLOT_W'(slot_reg);
            out_off_reg  <= off_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign ok          = out_ok_reg;
    assign slot        = out_slot_reg;
    assign byte_offset = out_off_reg;

endmodule

`default_nettype wire
